// ===== src/dba_pkg.sv =====
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and constants for the debounced band alarm.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int HeartW = 8;
  localparam int PaceW  = 12;
  localparam int CountW = 8;
  localparam int IndexW = 3;

  localparam logic [CountW-1:0] CountMax = '1;

  // configuration register indexes
  localparam logic [IndexW-1:0] REG_HEART_UPPER  = 3'd0;
  localparam logic [IndexW-1:0] REG_HEART_LOWER  = 3'd1;
  localparam logic [IndexW-1:0] REG_PACE_UPPER   = 3'd2;
  localparam logic [IndexW-1:0] REG_PACE_LOWER   = 3'd3;
  localparam logic [IndexW-1:0] REG_HEART_ENABLE = 3'd4;
  localparam logic [IndexW-1:0] REG_PACE_ENABLE  = 3'd5;
  localparam logic [IndexW-1:0] REG_DEBOUNCE     = 3'd6;
  localparam logic [IndexW-1:0] REG_REPEAT       = 3'd7;

  typedef enum logic [2:0] {
    CLS_NONE       = 3'd0,
    CLS_HEART_HIGH = 3'd1,
    CLS_HEART_LOW  = 3'd2,
    CLS_PACE_SLOW  = 3'd3,
    CLS_PACE_FAST  = 3'd4
  } class_t;

  typedef struct packed {
    logic [HeartW-1:0] heart_upper;
    logic [HeartW-1:0] heart_lower;
    logic [PaceW-1:0]  pace_upper;
    logic [PaceW-1:0]  pace_lower;
    logic              heart_enable;
    logic              pace_enable;
    logic [CountW-1:0] debounce_seconds;
    logic [CountW-1:0] repeat_seconds;
  } cfg_t;

endpackage

// ===== src/dba_cfg.sv =====
// ----------------------------------------------------------------------------
// dba_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module dba_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dba_pkg::IndexW-1:0]   cfg_index,
  input  logic [15:0]                  cfg_data,
  output dba_pkg::cfg_t                cfg
);

  dba_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.heart_upper      <= 8'd180;
      regs.heart_lower      <= 8'd100;
      regs.pace_upper       <= 12'd420;
      regs.pace_lower       <= 12'd240;
      regs.heart_enable     <= 1'b0;
      regs.pace_enable      <= 1'b0;
      regs.debounce_seconds <= 8'd5;
      regs.repeat_seconds   <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dba_pkg::REG_HEART_UPPER:  regs.heart_upper      <= cfg_data[7:0];
        dba_pkg::REG_HEART_LOWER:  regs.heart_lower      <= cfg_data[7:0];
        dba_pkg::REG_PACE_UPPER:   regs.pace_upper       <= cfg_data[11:0];
        dba_pkg::REG_PACE_LOWER:   regs.pace_lower       <= cfg_data[11:0];
        dba_pkg::REG_HEART_ENABLE: regs.heart_enable     <= cfg_data[0];
        dba_pkg::REG_PACE_ENABLE:  regs.pace_enable      <= cfg_data[0];
        dba_pkg::REG_DEBOUNCE:     regs.debounce_seconds <= cfg_data[7:0];
        dba_pkg::REG_REPEAT:       regs.repeat_seconds   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dba_classify.sv =====
// ----------------------------------------------------------------------------
// dba_classify
// Band classification of one sample: heart high/low first, then pace.
// ----------------------------------------------------------------------------
module dba_classify (
  input  dba_pkg::cfg_t                 cfg,
  input  logic                          heart_valid,
  input  logic [dba_pkg::HeartW-1:0]    heart_rate,
  input  logic [dba_pkg::PaceW-1:0]     pace_value,
  output dba_pkg::class_t               cls
);

  logic heart_use;
  logic pace_use;

  // a zero reading means no reading
  assign heart_use = heart_valid && cfg.heart_enable && (heart_rate != '0);
  assign pace_use  = cfg.pace_enable && (pace_value != '0);

  always_comb begin
    cls = dba_pkg::CLS_NONE;
    if (heart_use && (heart_rate > cfg.heart_upper)) begin
      cls = dba_pkg::CLS_HEART_HIGH;
    end else if (heart_use && (heart_rate < cfg.heart_lower)) begin
      cls = dba_pkg::CLS_HEART_LOW;
    end else if (pace_use && (pace_value > cfg.pace_upper)) begin
      cls = dba_pkg::CLS_PACE_SLOW;
    end else if (pace_use && (pace_value < cfg.pace_lower)) begin
      cls = dba_pkg::CLS_PACE_FAST;
    end
  end

endmodule

// ===== src/dba_track.sv =====
// ----------------------------------------------------------------------------
// dba_track
// Debounce and repeat tracking; decides the alert code of each sample.
// ----------------------------------------------------------------------------
module dba_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  dba_pkg::class_t      cls,
  input  dba_pkg::cfg_t        cfg,
  output dba_pkg::class_t      code
);

  dba_pkg::class_t              pending_class, pending_class_next;
  dba_pkg::class_t              last_fired_class, last_fired_class_next;
  logic [dba_pkg::CountW-1:0]   out_band_count, out_band_count_next;
  logic [dba_pkg::CountW-1:0]   since_fire_count, since_fire_count_next;
  logic [dba_pkg::CountW-1:0]   band_inc;
  logic [dba_pkg::CountW-1:0]   since_inc;

  // saturating increments
  assign band_inc  = (out_band_count == dba_pkg::CountMax) ? dba_pkg::CountMax
                                                           : out_band_count + 1'b1;
  assign since_inc = (since_fire_count == dba_pkg::CountMax) ? dba_pkg::CountMax
                                                             : since_fire_count + 1'b1;

  always_comb begin
    pending_class_next    = pending_class;
    last_fired_class_next = last_fired_class;
    out_band_count_next   = out_band_count;
    since_fire_count_next = since_fire_count;
    code                  = dba_pkg::CLS_NONE;
    if (cls == dba_pkg::CLS_NONE) begin
      pending_class_next    = dba_pkg::CLS_NONE;
      last_fired_class_next = dba_pkg::CLS_NONE;
      out_band_count_next   = '0;
      since_fire_count_next = '0;
    end else if (cls != pending_class) begin
      pending_class_next    = cls;
      out_band_count_next   = {{(dba_pkg::CountW-1){1'b0}}, 1'b1};
      since_fire_count_next = '0;
    end else begin
      out_band_count_next = band_inc;
      if (band_inc >= cfg.debounce_seconds) begin
        // hold off a repeat of the same alert
        if ((last_fired_class == cls) && (since_inc < cfg.repeat_seconds)) begin
          since_fire_count_next = since_inc;
        end else begin
          last_fired_class_next = cls;
          since_fire_count_next = '0;
          code                  = cls;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_class    <= dba_pkg::CLS_NONE;
      last_fired_class <= dba_pkg::CLS_NONE;
      out_band_count   <= '0;
      since_fire_count <= '0;
    end else if (advance) begin
      pending_class    <= pending_class_next;
      last_fired_class <= last_fired_class_next;
      out_band_count   <= out_band_count_next;
      since_fire_count <= since_fire_count_next;
    end
  end

endmodule

// ===== src/debounced_band_alarm.sv =====
// ----------------------------------------------------------------------------
// debounced_band_alarm
// Debounced heart rate and pace band alarm with repeat hold-off.
// ----------------------------------------------------------------------------
// Samples arrive on the input channel (in_valid / in_stall) with fields
// heart_valid, heart_rate and pace_value; each sample yields exactly one
// alert_code on the output channel (out_valid / out_stall), 0 when nothing
// fires. A transfer happens on a rising edge with valid high and stall low.
// A sample is captured in an input register, classified and tracked, and
// written to the result register. One sample per cycle is sustained while
// the receiver does not stall: the classify, count and compare logic
// between the two registers is combinational. When the receiver stalls,
// the result holds and the input register still takes one more sample;
// in_stall rises only when both are full. Reset clears the valid flags,
// returns the configuration to its defaults and clears the debounce
// state. Configuration writes (cfg_valid / cfg_ready, index and data) are
// always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
module debounced_band_alarm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        heart_valid,
  input  logic [dba_pkg::HeartW-1:0]  heart_rate,
  input  logic [dba_pkg::PaceW-1:0]   pace_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  alert_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dba_pkg::IndexW-1:0]  cfg_index,
  input  logic [15:0]                 cfg_data
);

  dba_pkg::cfg_t               cfg;
  dba_pkg::class_t             cls;
  dba_pkg::class_t             code;
  logic                        s1_valid;
  logic                        s1_heart_valid;
  logic [dba_pkg::HeartW-1:0]  s1_heart_rate;
  logic [dba_pkg::PaceW-1:0]   s1_pace_value;
  logic                        s1_move;
  logic                        advance;
  logic                        accept;

  assign s1_move  = !out_valid || !out_stall;
  assign advance  = s1_valid && s1_move;
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  dba_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dba_classify u_classify (
    .cfg         (cfg),
    .heart_valid (s1_heart_valid),
    .heart_rate  (s1_heart_rate),
    .pace_value  (s1_pace_value),
    .cls         (cls)
  );

  dba_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cls     (cls),
    .cfg     (cfg),
    .code    (code)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_heart_valid <= heart_valid;
      s1_heart_rate  <= heart_rate;
      s1_pace_value  <= pace_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alert_code <= code;
    end
  end

endmodule

// ===== src/dba_checker.sv =====
// ----------------------------------------------------------------------------
// dba_checker
// Port-level checks for the debounced band alarm, bound to the top level.
// ----------------------------------------------------------------------------
module dba_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] alert_code
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alert_code))
    else $error("stalled result changed");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alert_code <= 3'd4)
    else $error("alert code out of range");

  // input side only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // an accepted sample cannot vanish: if the output was idle and stays free
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid ##1 !out_stall |=> out_valid)
    else $error("accepted sample produced no result");

endmodule

bind debounced_band_alarm dba_checker u_dba_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .alert_code (alert_code)
);
